/* rtl/core/rrg_pkg.sv */
// shared types and constants for the request replay guard
`default_nettype none

package rrg_pkg;

    // digest layout
    localparam int DIGEST_WORDS = 4;
    localparam int WORD_W       = 64;

    // status codes
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_NOT_PERMITTED = 2'd1;
    localparam logic [1:0] ST_GENERIC       = 2'd2;
    localparam logic [1:0] ST_INVALID       = 2'd3;

    // presence codes
    localparam logic [1:0] PRES_ABSENT = 2'd0;
    localparam logic [1:0] PRES_ALL    = 2'd2;

    // register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_READY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LEN_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LEN_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAL_LEN_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAL_LEN_MAX  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_LEN_REQ   = 3'd6;

    // register reset values
    localparam logic [7:0] RST_ID_LEN_MIN   = 8'd1;
    localparam logic [7:0] RST_ID_LEN_MAX   = 8'd32;
    localparam logic [7:0] RST_CHAL_LEN_MIN = 8'd16;
    localparam logic [7:0] RST_CHAL_LEN_MAX = 8'd64;
    localparam logic [7:0] RST_SIG_LEN_REQ  = 8'd64;

    typedef struct packed {
        logic       key_ready;
        logic       sequence_mode;
        logic [7:0] id_len_min;
        logic [7:0] id_len_max;
        logic [7:0] chal_len_min;
        logic [7:0] chal_len_max;
        logic [7:0] sig_len_required;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                           presence;
        logic [7:0]                           id_len;
        logic [7:0]                           chal_len;
        logic [7:0]                           sig_len;
        logic                                 seq_present;
        logic [31:0]                          seq_number;
        logic                                 sig_ok;
        logic                                 hash_ok;
        logic [DIGEST_WORDS-1:0][WORD_W-1:0]  digest;
    } req_t;

    // what the front checks decide
    typedef enum logic [1:0] {
        ACT_REPLY,
        ACT_SEQ,
        ACT_NONCE
    } act_t;

    typedef struct packed {
        act_t       act;
        logic [1:0] status;
    } verdict_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/rrg_ifs.sv */
// request and response channel interfaces
`default_nettype none

interface rrg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  presence;
    logic [7:0]  id_len;
    logic [7:0]  chal_len;
    logic [7:0]  sig_len;
    logic        seq_present;
    logic [31:0] seq_number;
    logic        sig_ok;
    logic        hash_ok;
    logic [63:0] digest_w0;
    logic [63:0] digest_w1;
    logic [63:0] digest_w2;
    logic [63:0] digest_w3;

    modport source (
        output valid, presence, id_len, chal_len, sig_len, seq_present, seq_number,
               sig_ok, hash_ok, digest_w0, digest_w1, digest_w2, digest_w3,
        input  ready
    );
    modport sink (
        input  valid, presence, id_len, chal_len, sig_len, seq_present, seq_number,
               sig_ok, hash_ok, digest_w0, digest_w1, digest_w2, digest_w3,
        output ready
    );
endinterface

interface rrg_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       book_updated;

    modport source (output valid, status, book_updated, input ready);
    modport sink (input valid, status, book_updated, output ready);
endinterface

`default_nettype wire

/* rtl/core/request_replay_guard.sv */
// top level of the request replay guard: configuration registers and sequencer
`default_nettype none

// request_replay_guard: accept/reject gate for signed requests with replay protection.
// req channel: one beat per request (presence, lengths, sequence number, signature and
//   digest flags, 256-bit challenge digest in four 64-bit words).
// rsp channel: one beat per request with status and book_updated.
// cfg port: cfg_we/cfg_index/cfg_data write one register per cycle; write only while idle.
// path from the request beat to its result beat:
//   a rejection or a sequence-mode request goes from the check straight to the result.
//   a nonce-mode request scans the history ring one 64-bit word per cycle through the
//   history memory read port, over every stored digest; when the digest is found the
//   request is rejected, when it is new its four words are written into the ring.
// the next request is taken at the same edge as the earliest result beat.
// req.ready is high only while the sequencer is idle; one request is worked at a time.
// the result sits in an output register: a stalled rsp receiver holds the sequencer at
//   its final step but a new request can still be taken once that result is registered.
// reset: registers return to their defaults, high-water mark, ring count and write slot
//   clear; the history memory itself is not cleared, only entries below the count are read.
module request_replay_guard #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rrg_req_if.sink                            req,
    rrg_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [rrg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rrg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rrg_pkg::cfg_t cfg_reg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_ready        <= 1'b0;
            cfg_reg.sequence_mode    <= 1'b0;
            cfg_reg.id_len_min       <= rrg_pkg::RST_ID_LEN_MIN;
            cfg_reg.id_len_max       <= rrg_pkg::RST_ID_LEN_MAX;
            cfg_reg.chal_len_min     <= rrg_pkg::RST_CHAL_LEN_MIN;
            cfg_reg.chal_len_max     <= rrg_pkg::RST_CHAL_LEN_MAX;
            cfg_reg.sig_len_required <= rrg_pkg::RST_SIG_LEN_REQ;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rrg_pkg::CFG_KEY_READY:     cfg_reg.key_ready        <= cfg_data[0];
                rrg_pkg::CFG_SEQUENCE_MODE: cfg_reg.sequence_mode    <= cfg_data[0];
                rrg_pkg::CFG_ID_LEN_MIN:    cfg_reg.id_len_min       <= cfg_data;
                rrg_pkg::CFG_ID_LEN_MAX:    cfg_reg.id_len_max       <= cfg_data;
                rrg_pkg::CFG_CHAL_LEN_MIN:  cfg_reg.chal_len_min     <= cfg_data;
                rrg_pkg::CFG_CHAL_LEN_MAX:  cfg_reg.chal_len_max     <= cfg_data;
                rrg_pkg::CFG_SIG_LEN_REQ:   cfg_reg.sig_len_required <= cfg_data;
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // sequencer with check logic, history memory and result register
    rrg_ctrl #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg_reg)
    );

endmodule

`default_nettype wire

/* rtl/core/rrg_check.sv */
// front checks: presence, key, lengths, sequence, signature and hash
`default_nettype none

module rrg_check (
    input  rrg_pkg::req_t     req,
    input  rrg_pkg::cfg_t     cfg,
    input  logic [31:0]       hwm,
    output rrg_pkg::verdict_t verdict
);

    logic len_bad;

    assign len_bad = (req.presence != rrg_pkg::PRES_ALL)
                  || (req.id_len < cfg.id_len_min) || (req.id_len > cfg.id_len_max)
                  || (req.sig_len != cfg.sig_len_required)
                  || (req.chal_len < cfg.chal_len_min)
                  || (req.chal_len > cfg.chal_len_max);

    always_comb
    begin
        verdict.act    = rrg_pkg::ACT_REPLY;
        verdict.status = rrg_pkg::ST_NOT_PERMITTED;
        if (req.presence == rrg_pkg::PRES_ABSENT)
        begin
            verdict.status = rrg_pkg::ST_INVALID;
        end
        else if (!cfg.key_ready || len_bad)
        begin
            verdict.status = rrg_pkg::ST_NOT_PERMITTED;
        end
        else if (cfg.sequence_mode && (!req.seq_present || req.seq_number == 32'd0))
        begin
            verdict.status = rrg_pkg::ST_NOT_PERMITTED;
        end
        else if (!req.sig_ok)
        begin
            verdict.status = rrg_pkg::ST_NOT_PERMITTED;
        end
        else if (cfg.sequence_mode)
        begin
            // strictly higher than the high-water mark
            if (req.seq_number > hwm)
            begin
                verdict.act    = rrg_pkg::ACT_SEQ;
                verdict.status = rrg_pkg::ST_OK;
            end
        end
        else if (!req.hash_ok)
        begin
            verdict.status = rrg_pkg::ST_GENERIC;
        end
        else
        begin
            verdict.act    = rrg_pkg::ACT_NONCE;
            verdict.status = rrg_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rrg_hist.sv */
// digest history memory, one 64-bit word per entry, registered read
`default_nettype none

module rrg_hist #(
    parameter  int HISTORY_DEPTH = 16,
    localparam int WORDS         = rrg_pkg::DIGEST_WORDS * HISTORY_DEPTH,
    localparam int AW            = $clog2(WORDS)
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [rrg_pkg::WORD_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [rrg_pkg::WORD_W-1:0] wr_data
);

    logic [rrg_pkg::WORD_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rrg_ctrl.sv */
// sequencer: request capture, history scan with shared word comparator, result register
`default_nettype none

module rrg_ctrl #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    rrg_req_if.sink       req,
    rrg_rsp_if.source     rsp,
    input  rrg_pkg::cfg_t cfg
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int AW = $clog2(rrg_pkg::DIGEST_WORDS * HISTORY_DEPTH);

    rrg_pkg::state_t   state_reg, state_next;
    rrg_pkg::req_t     req_reg;
    rrg_pkg::verdict_t verdict;

    logic [31:0]   hwm_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] slot_reg;
    logic [CW+1:0] iss_reg;
    logic [CW+1:0] scan_total;
    logic          cmp_vld_reg;
    logic [1:0]    cmp_word_reg;
    logic          ent_eq_reg;
    logic          hit_reg;
    logic [1:0]    wcnt_reg;
    logic [1:0]    pend_status_reg;
    logic          pend_upd_reg;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic          out_upd_reg;

    logic in_fire;
    logic scan_issue;
    logic scan_end;
    logic word_eq;
    logic ent_eq_next;
    logic out_load;
    logic write_last;

    logic                       mem_rd_en;
    logic [AW-1:0]              mem_rd_addr;
    logic [rrg_pkg::WORD_W-1:0] mem_rd_data;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [rrg_pkg::WORD_W-1:0] mem_wr_data;

    rrg_check u_check (
        .req     (req_reg),
        .cfg     (cfg),
        .hwm     (hwm_reg),
        .verdict (verdict)
    );

    rrg_hist #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    assign req.ready     = (state_reg == rrg_pkg::S_IDLE);
    assign in_fire       = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.book_updated = out_upd_reg;

    assign scan_total  = {cnt_reg, 2'b00};
    assign scan_issue  = (state_reg == rrg_pkg::S_SCAN) && (iss_reg != scan_total);
    assign scan_end    = (state_reg == rrg_pkg::S_SCAN) && (iss_reg == scan_total)
                      && !cmp_vld_reg;
    // shared comparator: one stored word against the matching request word
    assign word_eq     = (mem_rd_data == req_reg.digest[cmp_word_reg]);
    assign ent_eq_next = word_eq && ((cmp_word_reg == 2'd0) || ent_eq_reg);
    assign write_last  = (state_reg == rrg_pkg::S_WRITE) && (wcnt_reg == 2'd3);
    assign out_load    = (state_reg == rrg_pkg::S_DONE) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrg_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = rrg_pkg::S_CHECK;
                end
            end
            rrg_pkg::S_CHECK:
            begin
                unique case (verdict.act) inside
                    rrg_pkg::ACT_REPLY, rrg_pkg::ACT_SEQ: state_next = rrg_pkg::S_DONE;
                    rrg_pkg::ACT_NONCE:                   state_next = rrg_pkg::S_SCAN;
                    default:                              state_next = rrg_pkg::S_DONE;
                endcase
            end
            rrg_pkg::S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = hit_reg ? rrg_pkg::S_DONE : rrg_pkg::S_WRITE;
                end
            end
            rrg_pkg::S_WRITE:
            begin
                if (write_last)
                begin
                    state_next = rrg_pkg::S_DONE;
                end
            end
            rrg_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = rrg_pkg::S_IDLE;
                end
            end
            default: state_next = rrg_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_rd_addr = iss_reg[AW-1:0];
        mem_wr_addr = AW'({slot_reg, wcnt_reg});
        mem_wr_data = req_reg.digest[wcnt_reg];
        unique case (state_reg)
            rrg_pkg::S_SCAN:  mem_rd_en = scan_issue;
            rrg_pkg::S_WRITE: mem_wr_en = 1'b1;
            default:
            begin
                mem_rd_en = 1'b0;
                mem_wr_en = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrg_pkg::S_IDLE;
            hwm_reg       <= '0;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            iss_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            wcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= scan_issue;
            if (state_reg == rrg_pkg::S_CHECK)
            begin
                iss_reg  <= '0;
                wcnt_reg <= '0;
                if (verdict.act == rrg_pkg::ACT_SEQ)
                begin
                    hwm_reg <= req_reg.seq_number;
                end
            end
            if (scan_issue)
            begin
                iss_reg <= iss_reg + 1'b1;
            end
            if (state_reg == rrg_pkg::S_WRITE)
            begin
                wcnt_reg <= wcnt_reg + 1'b1;
            end
            if (write_last)
            begin
                slot_reg <= (slot_reg == SW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                if (cnt_reg != CW'(HISTORY_DEPTH))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg.presence    <= req.presence;
            req_reg.id_len      <= req.id_len;
            req_reg.chal_len    <= req.chal_len;
            req_reg.sig_len     <= req.sig_len;
            req_reg.seq_present <= req.seq_present;
            req_reg.seq_number  <= req.seq_number;
            req_reg.sig_ok      <= req.sig_ok;
            req_reg.hash_ok     <= req.hash_ok;
            req_reg.digest      <= {req.digest_w3, req.digest_w2, req.digest_w1, req.digest_w0};
        end
        if (state_reg == rrg_pkg::S_CHECK)
        begin
            hit_reg         <= 1'b0;
            pend_status_reg <= verdict.status;
            pend_upd_reg    <= (verdict.act == rrg_pkg::ACT_SEQ);
        end
        if (scan_issue)
        begin
            cmp_word_reg <= iss_reg[1:0];
        end
        if (cmp_vld_reg)
        begin
            ent_eq_reg <= ent_eq_next;
            if (cmp_word_reg == 2'd3 && ent_eq_next)
            begin
                hit_reg <= 1'b1;
            end
        end
        if (scan_end && hit_reg)
        begin
            pend_status_reg <= rrg_pkg::ST_NOT_PERMITTED;
            pend_upd_reg    <= 1'b0;
        end
        if (write_last)
        begin
            pend_status_reg <= rrg_pkg::ST_OK;
            pend_upd_reg    <= 1'b1;
        end
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_upd_reg    <= pend_upd_reg;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(HISTORY_DEPTH))
        else $error("history count above ring size");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SW'(HISTORY_DEPTH - 1))
        else $error("write slot outside ring");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        write_last |=> (cnt_reg == CW'($past(cnt_reg) + 1'b1))
                    || (cnt_reg == CW'(HISTORY_DEPTH)))
        else $error("history count did not advance after a ring write");

    a_upd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_upd_reg |-> out_status_reg == rrg_pkg::ST_OK)
        else $error("store updated on a rejected request");
`endif

endmodule

`default_nettype wire

/* test/request_replay_guard_tb.sv */
// self-checking testbench for the request replay guard: directed table, then random phases
`timescale 1ns / 100ps

module request_replay_guard_tb;
    import rrg_pkg::*;

    localparam int RING_DEPTH     = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int POOL_SIZE      = 40;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 130;

    // presence codes the package leaves unnamed
    localparam logic [1:0] PRES_MISSING   = 2'd1;
    localparam logic [1:0] PRES_UNDEFINED = 2'd3;
    // register index past the end of the map
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] digest_t;

    typedef struct packed {
        logic [1:0] status;
        logic       book_updated;
    } verdict_beat_t;

    typedef enum logic { ROW_WRITE, ROW_REQUEST } row_kind_t;

    // one line of the directed table: a register write or a request beat
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        req_t                  request;
        bit                    typed;
        verdict_beat_t         verdict;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rrg_req_if req_ch();
    rrg_rsp_if rsp_ch();

    request_replay_guard #(
        .HISTORY_DEPTH (RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the guard: registers, high-water mark, digest ring
    cfg_t          regs;
    logic [31:0]   seq_mark;
    digest_t       history [RING_DEPTH];
    int            history_fill;
    int            history_slot;

    // verdicts owed by the guard, oldest first
    verdict_beat_t verdicts_due[$];
    // recently offered digests, drawn on to provoke replays
    digest_t       digest_pool[$];
    stim_row_t     script[$];

    int mismatches;
    int requests_sent;
    int results_checked;
    int status_seen [4];
    bit src_idle_on;
    bit snk_idle_on;
    int hold_request;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic flag_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch on result %0d: %s", $time, results_checked, what);
    endtask

    // register write as the guard decodes it: low bits only, unknown index dropped
    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_KEY_READY:     regs.key_ready        = data[0];
            CFG_SEQUENCE_MODE: regs.sequence_mode    = data[0];
            CFG_ID_LEN_MIN:    regs.id_len_min       = data;
            CFG_ID_LEN_MAX:    regs.id_len_max       = data;
            CFG_CHAL_LEN_MIN:  regs.chal_len_min     = data;
            CFG_CHAL_LEN_MAX:  regs.chal_len_max     = data;
            CFG_SIG_LEN_REQ:   regs.sig_len_required = data;
            default: ;
        endcase
    endfunction

    // verdict for one request beat; updates the shadow books on acceptance
    function automatic verdict_beat_t judge_request(req_t r);
        verdict_beat_t v;
        bit            seen;
        v.status       = ST_NOT_PERMITTED;
        v.book_updated = 1'b0;
        seen           = 1'b0;
        if (r.presence == PRES_ABSENT)
            v.status = ST_INVALID;
        else if (!regs.key_ready)
            v.status = ST_NOT_PERMITTED;
        else if (r.presence != PRES_ALL ||
                 r.id_len < regs.id_len_min || r.id_len > regs.id_len_max ||
                 r.sig_len != regs.sig_len_required ||
                 r.chal_len < regs.chal_len_min || r.chal_len > regs.chal_len_max)
            v.status = ST_NOT_PERMITTED;
        else if (regs.sequence_mode && (!r.seq_present || r.seq_number == '0))
            v.status = ST_NOT_PERMITTED;
        else if (!r.sig_ok)
            v.status = ST_NOT_PERMITTED;
        else if (regs.sequence_mode)
        begin
            // strictly above the high-water mark, which then moves up
            if (r.seq_number > seq_mark)
            begin
                seq_mark       = r.seq_number;
                v.status       = ST_OK;
                v.book_updated = 1'b1;
            end
        end
        else if (!r.hash_ok)
            v.status = ST_GENERIC;
        else
        begin
            for (int i = 0; i < history_fill; i++)
                if (history[i] == r.digest)
                    seen = 1'b1;
            if (!seen)
            begin
                history[history_slot] = r.digest;
                history_slot          = (history_slot + 1) % RING_DEPTH;
                if (history_fill < RING_DEPTH)
                    history_fill++;
                v.status       = ST_OK;
                v.book_updated = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic digest_t fresh_digest();
        digest_t d;
        for (int w = 0; w < DIGEST_WORDS; w++)
            d[w] = {$urandom, $urandom};
        return d;
    endfunction

    // a length the bounds allow; any length when they cross
    function automatic logic [7:0] len_within(logic [7:0] lo, logic [7:0] hi);
        if (lo > hi)
            return 8'($urandom);
        return 8'($urandom_range(hi, lo));
    endfunction

    // a length the bounds reject, where one exists
    function automatic logic [7:0] len_outside(logic [7:0] lo, logic [7:0] hi);
        if (lo > 0 && ($urandom_range(0, 1) == 1 || hi == 8'hFF))
            return 8'($urandom_range(lo - 1, 0));
        if (hi < 8'hFF)
            return 8'($urandom_range(255, hi + 1));
        return 8'($urandom);
    endfunction

    // mostly well-formed requests for the current setting, some broken, some noise
    function automatic req_t make_request();
        req_t r;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll >= 90)
        begin
            r.presence    = 2'($urandom);
            r.id_len      = 8'($urandom);
            r.chal_len    = 8'($urandom);
            r.sig_len     = 8'($urandom);
            r.seq_present = 1'($urandom);
            r.seq_number  = $urandom;
            r.sig_ok      = 1'($urandom);
            r.hash_ok     = 1'($urandom);
            r.digest      = fresh_digest();
            return r;
        end
        r.presence    = PRES_ALL;
        r.id_len      = len_within(regs.id_len_min, regs.id_len_max);
        r.chal_len    = len_within(regs.chal_len_min, regs.chal_len_max);
        r.sig_len     = regs.sig_len_required;
        r.seq_present = 1'b1;
        r.sig_ok      = 1'b1;
        r.hash_ok     = 1'b1;
        // next sequence numbers mostly climb, the rest replay or go stale
        if (!regs.sequence_mode)
            r.seq_number = $urandom;
        else if (seq_mark <= 32'hFFFF_F000 && $urandom_range(0, 5) != 0)
            r.seq_number = seq_mark + $urandom_range(1, 3000);
        else if (seq_mark > 2)
            r.seq_number = seq_mark - $urandom_range(0, 2);
        else
            r.seq_number = seq_mark;
        if (digest_pool.size() != 0 && $urandom_range(0, 99) < 40)
            r.digest = digest_pool[$urandom_range(0, digest_pool.size() - 1)];
        else
        begin
            r.digest = fresh_digest();
            digest_pool.push_back(r.digest);
            if (digest_pool.size() > POOL_SIZE)
                void'(digest_pool.pop_front());
        end
        if (roll >= 70)
        begin
            // alter one field so that at most one check breaks
            case ($urandom_range(0, 7))
                0:
                begin
                    r.presence = 2'($urandom);
                    if (r.presence == PRES_ALL)
                        r.presence = PRES_ABSENT;
                end
                1: r.id_len      = len_outside(regs.id_len_min, regs.id_len_max);
                2: r.chal_len    = len_outside(regs.chal_len_min, regs.chal_len_max);
                3: r.sig_len     = regs.sig_len_required + 8'($urandom_range(1, 255));
                4: r.seq_present = 1'b0;
                5: r.seq_number  = '0;
                6: r.sig_ok      = 1'b0;
                default: r.hash_ok = 1'b0;
            endcase
        end
        return r;
    endfunction

    // offer one request beat and log its verdict once it is taken
    task automatic send_req(req_t r, bit typed, verdict_beat_t want);
        verdict_beat_t got;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        {req_ch.presence, req_ch.id_len, req_ch.chal_len, req_ch.sig_len,
         req_ch.seq_present, req_ch.seq_number, req_ch.sig_ok, req_ch.hash_ok,
         req_ch.digest_w3, req_ch.digest_w2, req_ch.digest_w1, req_ch.digest_w0} <= r;
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        requests_sent++;
        // the shadow books must move even when the verdict is typed in
        got = judge_request(r);
        if (typed)
            got = want;
        verdicts_due.push_back(got);
    endtask

    // sender stops and waits until every verdict is back and the guard is idle
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_setting(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // a fresh register setting per phase, extremes among them
    task automatic new_setting(int ph);
        logic [7:0] key;
        logic [7:0] mode;
        logic [7:0] id_lo;
        logic [7:0] id_hi;
        logic [7:0] ch_lo;
        logic [7:0] ch_hi;
        logic [7:0] sig_req;
        logic [7:0] a;
        logic [7:0] b;
        int         shape;
        shape   = (ph == 7) ? 3 : ph % 3;
        // upper bits are junk the guard must mask off
        key     = {7'($urandom), ph != 6};
        mode    = {7'($urandom), 1'((ph / 2) % 2)};
        sig_req = 8'($urandom);
        case (shape)
            0:
            begin
                id_lo   = 8'h00;
                id_hi   = 8'hFF;
                ch_lo   = 8'h00;
                ch_hi   = 8'hFF;
                sig_req = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
            1:
            begin
                a     = 8'($urandom);
                b     = 8'($urandom);
                id_lo = (a < b) ? a : b;
                id_hi = (a < b) ? b : a;
                a     = 8'($urandom);
                b     = 8'($urandom);
                ch_lo = (a < b) ? a : b;
                ch_hi = (a < b) ? b : a;
            end
            2:
            begin
                id_lo = 8'hFF;
                id_hi = 8'hFF;
                ch_lo = 8'h00;
                ch_hi = 8'h00;
            end
            default:
            begin
                // identifier bounds crossed: no length can pass
                id_lo = 8'($urandom_range(255, 129));
                id_hi = 8'($urandom_range(128, 0));
                ch_lo = 8'($urandom_range(40, 0));
                ch_hi = 8'($urandom_range(255, 41));
            end
        endcase
        settle();
        write_register(CFG_KEY_READY, key);
        write_register(CFG_SEQUENCE_MODE, mode);
        write_register(CFG_ID_LEN_MIN, id_lo);
        write_register(CFG_ID_LEN_MAX, id_hi);
        write_register(CFG_CHAL_LEN_MIN, ch_lo);
        write_register(CFG_CHAL_LEN_MAX, ch_hi);
        write_register(CFG_SIG_LEN_REQ, sig_req);
    endtask

    task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind    = ROW_WRITE;
        row.index   = idx;
        row.data    = data;
        row.request = '0;
        row.typed   = 1'b0;
        row.verdict = '0;
        script.push_back(row);
    endtask

    // typed-in rows are all rejections, so nothing is booked
    task automatic add_checked(req_t r, logic [1:0] st);
        stim_row_t row;
        row.kind                 = ROW_REQUEST;
        row.index                = '0;
        row.data                 = '0;
        row.request              = r;
        row.typed                = 1'b1;
        row.verdict.status       = st;
        row.verdict.book_updated = 1'b0;
        script.push_back(row);
    endtask

    task automatic add_predicted(req_t r);
        stim_row_t row;
        row.kind    = ROW_REQUEST;
        row.index   = '0;
        row.data    = '0;
        row.request = r;
        row.typed   = 1'b0;
        row.verdict = '0;
        script.push_back(row);
    endtask

    // response side: checks each beat and stalls in bursts or one long hold-off
    initial
    begin : result_sink
        int            stall_left;
        int            hold_left;
        logic          nxt;
        verdict_beat_t want;
        stall_left = 0;
        hold_left  = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_checked++;
                status_seen[rsp_ch.status]++;
                if (verdicts_due.size() == 0)
                    flag_mismatch($sformatf("beat with no request pending, status %0d",
                                            rsp_ch.status));
                else
                begin
                    want = verdicts_due.pop_front();
                    if (rsp_ch.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                rsp_ch.status, want.status));
                    if (rsp_ch.book_updated !== want.book_updated)
                        flag_mismatch($sformatf("book_updated %0b, expected %0b",
                                                rsp_ch.book_updated, want.book_updated));
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt = 1'b0;
            end
            else if (snk_idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                nxt        = 1'b0;
            end
            else
                nxt = 1'b1;
            rsp_ch.ready <= nxt;
        end
    end

    // ends the run when no beat moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 quiet, verdicts_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        req_t ok;
        req_t r;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        req_ch.valid <= 1'b0;
        {req_ch.presence, req_ch.id_len, req_ch.chal_len, req_ch.sig_len,
         req_ch.seq_present, req_ch.seq_number, req_ch.sig_ok, req_ch.hash_ok,
         req_ch.digest_w3, req_ch.digest_w2, req_ch.digest_w1, req_ch.digest_w0} <= '0;

        // shadow state after reset
        regs = {1'b0, 1'b0, RST_ID_LEN_MIN, RST_ID_LEN_MAX,
                RST_CHAL_LEN_MIN, RST_CHAL_LEN_MAX, RST_SIG_LEN_REQ};
        seq_mark     = '0;
        history_fill = 0;
        history_slot = 0;
        src_idle_on  = 1'b1;
        snk_idle_on  = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a request that passes every default bound
        ok             = '0;
        ok.presence    = PRES_ALL;
        ok.id_len      = 8'd16;
        ok.chal_len    = 8'd32;
        ok.sig_len     = 8'd64;
        ok.seq_present = 1'b1;
        ok.seq_number  = 32'd5;
        ok.sig_ok      = 1'b1;
        ok.hash_ok     = 1'b1;
        ok.digest      = fresh_digest();

        // out of reset the key is not loaded
        r = '0;
        add_checked(r, ST_INVALID);
        add_checked(ok, ST_NOT_PERMITTED);
        r          = '1;
        r.presence = PRES_ABSENT;
        add_checked(r, ST_INVALID);
        // only bit 0 of key_ready counts; unmapped index is dropped
        add_write(CFG_KEY_READY, 8'hFE);
        add_write(CFG_UNMAPPED, 8'hFF);
        add_checked(ok, ST_NOT_PERMITTED);
        add_write(CFG_KEY_READY, 8'h01);

        // each front check on its own, nonce mode
        r = ok; r.presence = PRES_MISSING;   add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.presence = PRES_UNDEFINED; add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.id_len   = 8'd0;           add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.id_len   = 8'd33;          add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.chal_len = 8'd15;          add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.chal_len = 8'd65;          add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.sig_len  = 8'd63;          add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.sig_ok   = 1'b0;           add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.hash_ok  = 1'b0;           add_checked(r, ST_GENERIC);

        // bounds inclusive at both ends, then the same digest replayed
        r = ok; r.id_len = 8'd1;  r.chal_len = 8'd16; add_predicted(r);
        r.id_len = 8'd32; r.chal_len = 8'd64;         add_predicted(r);
        // nonce mode ignores the sequence number
        r = ok; r.seq_present = 1'b0; r.seq_number = '0; r.digest = '1;
        add_predicted(r);

        add_write(CFG_SEQUENCE_MODE, 8'h01);
        r = ok; r.seq_present = 1'b0; add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.seq_number  = '0;   add_checked(r, ST_NOT_PERMITTED);
        r = ok; r.seq_number  = 32'd7;
        add_predicted(r);
        add_predicted(r);
        r.seq_number = 32'd6;
        add_predicted(r);
        // digest failure does not matter in sequence mode
        r = ok; r.seq_number = 32'd9; r.hash_ok = 1'b0;
        add_predicted(r);

        // minimum above maximum: every identifier length fails
        add_write(CFG_ID_LEN_MIN, 8'd40);
        add_write(CFG_ID_LEN_MAX, 8'd20);
        r = ok; r.id_len = 8'd30; r.seq_number = 32'd10;
        add_checked(r, ST_NOT_PERMITTED);

        add_write(CFG_ID_LEN_MIN, 8'h00);
        add_write(CFG_ID_LEN_MAX, 8'hFF);
        add_write(CFG_CHAL_LEN_MIN, 8'h00);
        add_write(CFG_CHAL_LEN_MAX, 8'hFF);
        add_write(CFG_SIG_LEN_REQ, 8'h00);
        r = ok; r.id_len = 8'h00; r.chal_len = 8'hFF; r.sig_len = 8'h00; r.seq_number = 32'd10;
        add_predicted(r);
        r.id_len = 8'hFF; r.chal_len = 8'h00; r.seq_number = 32'd11;
        add_predicted(r);

        // back to nonce mode: the ring kept its digests across the switch
        add_write(CFG_SEQUENCE_MODE, 8'h00);
        r = ok; r.sig_len = 8'h00; r.id_len = 8'hFF; r.chal_len = 8'h00;
        add_predicted(r);

        foreach (script[k])
        begin
            if (script[k].kind == ROW_WRITE)
            begin
                settle();
                write_register(script[k].index, script[k].data);
            end
            else
                send_req(script[k].request, script[k].typed, script[k].verdict);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // the closing phases run with no idling at all
            src_idle_on = (ph < PHASES - 2) && ((ph % 4) inside {0, 1});
            snk_idle_on = (ph < PHASES - 2) && ((ph % 4) inside {0, 2});
            new_setting(ph);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while beats keep coming: fills the guard
                if (ph == 2 && n == 30)
                    hold_request = LONG_HOLD;
                // sender pause mid-phase until every verdict is back
                if (ph == 5 && n == 60)
                    settle();
                send_req(make_request(), 1'b0, '0);
            end
        end

        settle();
        repeat (12) @(posedge clk);

        $display("covered %0d requests: %0d table rows, then %0d random register settings",
                 requests_sent, script.size(), PHASES);
        $display("verdicts: %0d accepted, %0d not permitted, %0d generic, %0d invalid",
                 status_seen[ST_OK], status_seen[ST_NOT_PERMITTED],
                 status_seen[ST_GENERIC], status_seen[ST_INVALID]);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rrg_pkg.sv
rtl/core/rrg_ifs.sv
rtl/core/rrg_check.sv
rtl/core/rrg_hist.sv
rtl/core/rrg_ctrl.sv
rtl/core/request_replay_guard.sv
test/request_replay_guard_tb.sv
